>>> rtl/dlb_pkg.sv
// Shared types, codes and constants for the decimal limb bignum ALU.
`timescale 1ns / 1ps

package dlb_pkg;

  // Limb radix and the reciprocal used to split a cell sum into digit and carry
  localparam int          RADIX      = 10000;
  localparam int          LIMBS_DEF  = 256;
  localparam int          SUM_W      = 27;
  localparam logic [23:0] RECIP_625  = 24'd13743896;
  localparam int          RECIP_SH   = 33;

  // Transaction commands
  localparam logic [2:0] CMD_LOAD  = 3'd0;
  localparam logic [2:0] CMD_WRITE = 3'd1;
  localparam logic [2:0] CMD_MUL   = 3'd2;
  localparam logic [2:0] CMD_ADD   = 3'd3;
  localparam logic [2:0] CMD_POW   = 3'd4;
  localparam logic [2:0] CMD_READ  = 3'd5;

  // Cell step kinds
  localparam logic [1:0] STEP_NONE  = 2'd0;
  localparam logic [1:0] STEP_SHIFT = 2'd1;
  localparam logic [1:0] STEP_HOLD  = 2'd2;
  localparam logic [1:0] STEP_DBL   = 2'd3;

  // Partial product register updates
  localparam logic [1:0] M_KEEP = 2'd0;
  localparam logic [1:0] M_ZERO = 2'd1;
  localparam logic [1:0] M_MUL  = 2'd2;
  localparam logic [1:0] M_OPND = 2'd3;

  // Digit shift register load sources
  localparam logic [1:0] Q_ACC  = 2'd0;
  localparam logic [1:0] Q_OPND = 2'd1;
  localparam logic [1:0] Q_BASE = 2'd2;
  localparam logic [1:0] Q_PROD = 2'd3;

  // Data handed from one cell to the next
  typedef struct packed {
    logic [13:0] p;
    logic [13:0] c;
    logic [13:0] cin;
    logic [13:0] q;
  } link_t;

  // Control broadcast to every cell
  typedef struct packed {
    logic [1:0]  step;
    logic [1:0]  mset;
    logic        pclr;
    logic        pfroma;
    logic        qload;
    logic [1:0]  qsrc;
    logic        qshift;
    logic        commit;
    logic        set_one;
    logic        bcopy;
    logic        wr_en;
    logic [7:0]  wr_idx;
    logic [13:0] wr_val;
  } ctl_t;

endpackage

>>> rtl/decimal_limb_bignum_alu.sv
// Top level: command sequencer driving a row of base-10000 limb cells.
//
//   channel | ports                                          | direction
//   --------+------------------------------------------------+----------
//   in      | in_valid in_stall in_cmd in_value in_limb_index | into block
//           | in_limb_value in_operand_sign_in                |
//   out     | out_valid out_stall out_limb_out out_acc_sign   | out of block
//           | out_acc_size out_overflow                       |
//
// One transaction at a time. Every command ends with a scan of the accumulator
// for size and limb read. Multiply before the scan: operand load, Horner feed
// through the cell row, carry flush, commit. Add: carry flush and commit before
// the scan. Load: doubling steps plus a flush. Power: up to 24 multiplies.
// rst_n clears accumulator, operand and signs. A stalled result is held; the
// next transaction can be taken while it waits.
`timescale 1ns / 1ps

module decimal_limb_bignum_alu #(
  parameter int LIMBS = dlb_pkg::LIMBS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_cmd,
  input  logic signed [63:0] in_value,
  input  logic [7:0]         in_limb_index,
  input  logic [13:0]        in_limb_value,
  input  logic signed [1:0]  in_operand_sign_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [13:0]        out_limb_out,
  output logic signed [1:0]  out_acc_sign,
  output logic [8:0]         out_acc_size,
  output logic               out_overflow
);

  localparam int CW = ($clog2(LIMBS + 2) > 7) ? $clog2(LIMBS + 2) : 7;
  localparam int SW = $clog2(LIMBS + 1);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_DBL    = 4'd1;
  localparam logic [3:0] ST_FLUSH  = 4'd2;
  localparam logic [3:0] ST_MULLD  = 4'd3;
  localparam logic [3:0] ST_MULRUN = 4'd4;
  localparam logic [3:0] ST_COMMIT = 4'd5;
  localparam logic [3:0] ST_SCANLD = 4'd6;
  localparam logic [3:0] ST_SCAN   = 4'd7;
  localparam logic [3:0] ST_FIN    = 4'd8;

  logic [3:0]        state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [2:0]        cmd_r;
  logic [63:0]       val_r;
  logic [63:0]       mag_r;
  logic [7:0]        idx_r;
  logic [11:0]       e_r;
  logic [3:0]        pw_bit_r;
  logic              pw_ph_r;
  logic              ovf_r;
  logic              found_r;
  logic [SW-1:0]     size_r;
  logic [13:0]       limb_r;
  logic signed [1:0] acc_sign_r, op_sign_r;
  logic              out_valid_r;
  logic [13:0]       out_limb_r;
  logic signed [1:0] out_sign_r;
  logic [8:0]        out_size_r;
  logic              out_ovf_r;

  logic              acc_in;
  logic [13:0]       wr_sat;
  logic [63:0]       in_mag;
  logic [1:0]        mul_src;
  logic              pw_more, pw_base;
  logic signed [1:0] sign_f;
  logic [SW-1:0]     size_f;

  dlb_pkg::ctl_t     ctl;
  dlb_pkg::link_t    lnk [LIMBS+1];
  logic [LIMBS-1:0]  drops;
  logic [13:0]       q_top;

  assign in_stall = (state_r != ST_IDLE);
  assign acc_in   = in_valid && !in_stall;
  assign wr_sat   = (in_limb_value > 14'd9999) ? 14'd9999 : in_limb_value;
  assign in_mag   = in_value[63] ? (64'd0 - in_value) : in_value;
  assign mul_src  = (cmd_r == dlb_pkg::CMD_MUL) ? dlb_pkg::Q_OPND :
                    (pw_ph_r ? dlb_pkg::Q_BASE : dlb_pkg::Q_ACC);
  assign q_top    = lnk[LIMBS].q;

  // Power step after a commit: multiply by base, or square for the next bit
  assign pw_base = !pw_ph_r && e_r[pw_bit_r];
  assign pw_more = (cmd_r == dlb_pkg::CMD_POW) && (pw_base || (pw_bit_r != 4'd0));

  function automatic logic signed [1:0] sgn_mul(input logic signed [1:0] x,
                                                input logic signed [1:0] y);
    if (x == 2'sd0 || y == 2'sd0) return 2'sd0;
    return (x == y) ? 2'sd1 : -2'sd1;
  endfunction

  // Drive the cell row
  always_comb begin
    ctl        = '0;
    ctl.step   = dlb_pkg::STEP_NONE;
    ctl.mset   = dlb_pkg::M_KEEP;
    ctl.qsrc   = dlb_pkg::Q_ACC;
    ctl.wr_idx = in_limb_index;
    ctl.wr_val = wr_sat;
    case (state_r)
      ST_IDLE: begin
        if (acc_in) begin
          case (in_cmd)
            dlb_pkg::CMD_LOAD: begin
              ctl.pclr = 1'b1;
              ctl.mset = dlb_pkg::M_ZERO;
            end
            dlb_pkg::CMD_WRITE: ctl.wr_en = 1'b1;
            dlb_pkg::CMD_ADD: begin
              ctl.pfroma = 1'b1;
              ctl.mset   = dlb_pkg::M_OPND;
            end
            dlb_pkg::CMD_POW: begin
              ctl.set_one = 1'b1;
              ctl.bcopy   = (in_value[11:0] != 12'd0);
            end
            default: ctl.pclr = 1'b0;
          endcase
        end
      end
      ST_DBL: ctl.step = dlb_pkg::STEP_DBL;
      ST_FLUSH: begin
        ctl.step = dlb_pkg::STEP_HOLD;
        ctl.mset = dlb_pkg::M_ZERO;
      end
      ST_MULLD: begin
        ctl.pclr  = 1'b1;
        ctl.mset  = dlb_pkg::M_ZERO;
        ctl.qload = 1'b1;
        ctl.qsrc  = mul_src;
      end
      ST_MULRUN: begin
        if (cnt_r < CW'(LIMBS)) begin
          ctl.mset   = dlb_pkg::M_MUL;
          ctl.qshift = 1'b1;
        end else begin
          ctl.mset = dlb_pkg::M_ZERO;
        end
        if (cnt_r != '0) ctl.step = dlb_pkg::STEP_SHIFT;
      end
      ST_COMMIT: begin
        ctl.commit = 1'b1;
        ctl.qload  = 1'b1;
        ctl.qsrc   = dlb_pkg::Q_PROD;
      end
      ST_SCANLD: begin
        ctl.qload = 1'b1;
        ctl.qsrc  = dlb_pkg::Q_ACC;
      end
      ST_SCAN: ctl.qshift = 1'b1;
      default: ctl.step = dlb_pkg::STEP_NONE;
    endcase
  end

  // Row of limb cells, limb 0 at the bottom
  assign lnk[0] = '0;
  for (genvar i = 0; i < LIMBS; i++) begin : g_cell
    dlb_cell #(
      .IDX (i),
      .TOP (i == LIMBS - 1)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl),
      .q_top (q_top),
      .inj   ((i == 0) ? ((state_r == ST_DBL) && mag_r[63]) : 1'b0),
      .nb    (lnk[i]),
      .lk    (lnk[i+1]),
      .drop  (drops[i])
    );
  end

  // Next state and counter
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r + CW'(1);
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (acc_in) begin
          case (in_cmd)
            dlb_pkg::CMD_LOAD: state_nxt = ST_DBL;
            dlb_pkg::CMD_ADD:  state_nxt = ST_FLUSH;
            dlb_pkg::CMD_MUL:  state_nxt = ST_MULLD;
            dlb_pkg::CMD_POW:  state_nxt = (in_value[11:0] != 12'd0) ? ST_MULLD : ST_SCANLD;
            default:           state_nxt = ST_SCANLD;
          endcase
        end
      end
      ST_DBL: begin
        if (cnt_r == CW'(63)) begin
          state_nxt = ST_FLUSH;
          cnt_nxt   = '0;
        end
      end
      ST_FLUSH: begin
        if (cnt_r == CW'(LIMBS)) begin
          state_nxt = ST_COMMIT;
          cnt_nxt   = '0;
        end
      end
      ST_MULLD: begin
        state_nxt = ST_MULRUN;
        cnt_nxt   = '0;
      end
      ST_MULRUN: begin
        if (cnt_r == CW'(LIMBS)) begin
          state_nxt = ST_FLUSH;
          cnt_nxt   = '0;
        end
      end
      ST_COMMIT: begin
        state_nxt = pw_more ? ST_MULLD : ST_SCAN;
        cnt_nxt   = '0;
      end
      ST_SCANLD: begin
        state_nxt = ST_SCAN;
        cnt_nxt   = '0;
      end
      ST_SCAN: begin
        if (cnt_r == CW'(LIMBS - 1)) begin
          state_nxt = ST_FIN;
          cnt_nxt   = '0;
        end
      end
      ST_FIN: begin
        cnt_nxt = '0;
        if (!(out_valid_r && out_stall)) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Final sign and size of the transaction
  always_comb begin
    size_f = found_r ? size_r : '0;
    case (cmd_r)
      dlb_pkg::CMD_LOAD: sign_f = val_r[63] ? -2'sd1 : 2'sd1;
      dlb_pkg::CMD_MUL:  sign_f = sgn_mul(acc_sign_r, op_sign_r);
      dlb_pkg::CMD_ADD:  sign_f = 2'sd1;
      dlb_pkg::CMD_POW: begin
        if (e_r == 12'd0)  sign_f = 2'sd1;
        else if (e_r[0])   sign_f = acc_sign_r;
        else               sign_f = sgn_mul(acc_sign_r, acc_sign_r);
      end
      default:           sign_f = acc_sign_r;
    endcase
    if (size_f == '0) sign_f = 2'sd0;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      acc_sign_r  <= 2'sd0;
      op_sign_r   <= 2'sd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (acc_in && (in_cmd == dlb_pkg::CMD_WRITE)) begin
        op_sign_r <= (in_operand_sign_in == 2'sd1) ? 2'sd1 :
                     ((in_operand_sign_in == 2'sd0) ? 2'sd0 : -2'sd1);
      end
      // Load a new result, or drop the one just taken
      if ((state_r == ST_FIN) && !(out_valid_r && out_stall)) begin
        out_valid_r <= 1'b1;
        acc_sign_r  <= sign_f;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Transaction registers, power stepping, scan capture
  always_ff @(posedge clk) begin
    if (acc_in) begin
      cmd_r    <= in_cmd;
      val_r    <= in_value;
      mag_r    <= in_mag;
      idx_r    <= in_limb_index;
      e_r      <= in_value[11:0];
      pw_bit_r <= 4'd11;
      pw_ph_r  <= 1'b0;
      ovf_r    <= 1'b0;
      found_r  <= 1'b0;
      size_r   <= '0;
      limb_r   <= '0;
    end else begin
      if (state_r == ST_DBL) mag_r <= {mag_r[62:0], 1'b0};
      if (drops[LIMBS-1]) ovf_r <= 1'b1;
      if ((state_r == ST_COMMIT) && pw_more) begin
        if (pw_base) begin
          pw_ph_r <= 1'b1;
        end else begin
          pw_ph_r  <= 1'b0;
          pw_bit_r <= pw_bit_r - 4'd1;
        end
      end
      if (state_r == ST_SCAN) begin
        if (!found_r && (q_top != '0)) begin
          found_r <= 1'b1;
          size_r  <= SW'(LIMBS - int'(cnt_r));
        end
        if ((LIMBS - 1 - int'(cnt_r)) == int'(idx_r)) limb_r <= q_top;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if ((state_r == ST_FIN) && !(out_valid_r && out_stall)) begin
      out_limb_r <= (cmd_r == dlb_pkg::CMD_READ) ? limb_r : 14'd0;
      out_sign_r <= sign_f;
      out_size_r <= 9'(size_f);
      out_ovf_r  <= ((cmd_r == dlb_pkg::CMD_MUL) || (cmd_r == dlb_pkg::CMD_ADD) ||
                     (cmd_r == dlb_pkg::CMD_POW)) && ovf_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_limb_out = out_limb_r;
  assign out_acc_sign = out_sign_r;
  assign out_acc_size = out_size_r;
  assign out_overflow = out_ovf_r;

endmodule

>>> rtl/dlb_cell.sv
// One limb cell: accumulator, operand and base digits, carry-save product digit.
`timescale 1ns / 1ps

module dlb_cell #(
  parameter int IDX = 0,
  parameter bit TOP = 1'b0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  dlb_pkg::ctl_t   ctl,
  input  logic [13:0]     q_top,
  input  logic            inj,
  input  dlb_pkg::link_t  nb,
  output dlb_pkg::link_t  lk,
  output logic            drop
);

  logic [13:0] a_r, o_r, bs_r, p_r, c_r, q_r;
  logic [dlb_pkg::SUM_W-1:0] m_r;
  logic [dlb_pkg::SUM_W-1:0] pin, cin, t, rem;
  logic [22:0] n;
  logic [46:0] prod;
  logic [13:0] qt;
  logic [27:0] mul;

  // Select the step operands
  always_comb begin
    case (ctl.step)
      dlb_pkg::STEP_SHIFT: begin
        pin = dlb_pkg::SUM_W'(nb.p);
        cin = dlb_pkg::SUM_W'(nb.cin);
      end
      dlb_pkg::STEP_HOLD: begin
        pin = dlb_pkg::SUM_W'(p_r);
        cin = dlb_pkg::SUM_W'(nb.c);
      end
      dlb_pkg::STEP_DBL: begin
        pin = dlb_pkg::SUM_W'({p_r, 1'b0});
        cin = dlb_pkg::SUM_W'({nb.c, 1'b0});
      end
      default: begin
        pin = '0;
        cin = '0;
      end
    endcase
  end

  // Split the sum into digit and carry: divide by 16, then by 625 via reciprocal
  always_comb begin
    t    = pin + m_r + cin + dlb_pkg::SUM_W'(inj);
    n    = t[dlb_pkg::SUM_W-1:4];
    prod = 47'(n) * 47'(dlb_pkg::RECIP_625);
    qt   = prod[46:dlb_pkg::RECIP_SH];
    rem  = t - dlb_pkg::SUM_W'(qt) * dlb_pkg::SUM_W'(dlb_pkg::RADIX);
    mul  = 28'(q_top) * 28'(a_r);
  end

  // Flag anything pushed past the top limb
  assign drop = TOP && (ctl.step != dlb_pkg::STEP_NONE) &&
                ((qt != '0) ||
                 ((ctl.step == dlb_pkg::STEP_SHIFT) && ((p_r != '0) || (nb.c != '0))));

  // Partial product register
  always_ff @(posedge clk) begin
    case (ctl.mset)
      dlb_pkg::M_ZERO: m_r <= '0;
      dlb_pkg::M_MUL:  m_r <= mul[dlb_pkg::SUM_W-1:0];
      dlb_pkg::M_OPND: m_r <= dlb_pkg::SUM_W'(o_r);
      default:         m_r <= m_r;
    endcase
  end

  // Product digit and pending carry
  always_ff @(posedge clk) begin
    if (ctl.pclr) begin
      p_r <= '0;
      c_r <= '0;
    end else if (ctl.pfroma) begin
      p_r <= a_r;
      c_r <= '0;
    end else if (ctl.step != dlb_pkg::STEP_NONE) begin
      p_r <= rem[13:0];
      c_r <= TOP ? 14'd0 : qt;
    end
  end

  // Digit shift register
  always_ff @(posedge clk) begin
    if (ctl.qload) begin
      case (ctl.qsrc)
        dlb_pkg::Q_ACC:  q_r <= a_r;
        dlb_pkg::Q_OPND: q_r <= o_r;
        dlb_pkg::Q_BASE: q_r <= bs_r;
        default:         q_r <= p_r;
      endcase
    end else if (ctl.qshift) begin
      q_r <= nb.q;
    end
  end

  // Power base copy
  always_ff @(posedge clk) begin
    if (ctl.bcopy) begin
      bs_r <= a_r;
    end
  end

  // Accumulator and operand digits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r <= '0;
      o_r <= '0;
    end else begin
      if (ctl.commit) begin
        a_r <= p_r;
      end else if (ctl.set_one) begin
        a_r <= (IDX == 0) ? 14'd1 : 14'd0;
      end
      if (ctl.wr_en && (int'(ctl.wr_idx) == IDX)) begin
        o_r <= ctl.wr_val;
      end
    end
  end

  assign lk.p   = p_r;
  assign lk.c   = c_r;
  assign lk.cin = nb.c;
  assign lk.q   = q_r;

endmodule
